>>> hdl/prtc_pkg.sv
// Shared types and constants for the pulse rate from threshold crossings block.
package prtc_pkg;

   localparam int SAMPLE_BITS   = 18;
   localparam int TIME_BITS     = 32;
   localparam int INTERVAL_BITS = 16;
   localparam int BPM_BITS      = 8;
   localparam int SWING_BITS    = 18;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 18;
   localparam int MOD_BITS      = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_SWING    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FALLBACK_THR = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_INTERVAL = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_INTERVAL = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BPM_LOW      = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BPM_HIGH     = 3'd5;

   // configuration reset values
   localparam logic [SWING_BITS-1:0]    MIN_SWING_RESET    = 18'd1000;
   localparam logic [SWING_BITS-1:0]    FALLBACK_THR_RESET = 18'd50000;
   localparam logic [INTERVAL_BITS-1:0] MIN_INTERVAL_RESET = 16'd300;
   localparam logic [INTERVAL_BITS-1:0] MAX_INTERVAL_RESET = 16'd1500;
   localparam logic [BPM_BITS-1:0]      BPM_LOW_RESET      = 8'd40;
   localparam logic [BPM_BITS-1:0]      BPM_HIGH_RESET     = 8'd180;

   localparam logic [INTERVAL_BITS-1:0] RATE_NUMERATOR = 16'd60000;
   localparam logic [1:0]               THIRD_DIVISOR  = 2'd3;
   localparam logic [MOD_BITS-1:0]      MOD_TEN_LAST   = 4'd9;
   localparam logic [MOD_BITS-1:0]      MOD_TWO        = 4'd2;

   typedef struct packed {
      logic [TIME_BITS-1:0]   time_ms;
      logic [SAMPLE_BITS-1:0] ir_sample;
   } req_payload_type;

   typedef struct packed {
      logic [BPM_BITS-1:0] heart_bpm;
      logic                beat_seen;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_THRESH,
      ST_THRESH_WAIT,
      ST_CROSS,
      ST_AVG,
      ST_AVG_WAIT,
      ST_RANGE,
      ST_RATE_WAIT,
      ST_FINISH
   } state_type;

endpackage

>>> hdl/prtc_div.sv
// Restoring divider that retires one quotient bit per cycle.
module prtc_div #(
   parameter int NUM_W = 19,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = denom;
         quo_in  = numer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

>>> hdl/prtc_ring.sv
// Ring of beat intervals with a running sum and a fill count.
module prtc_ring
   import prtc_pkg::*;
#(
   parameter int RING_DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      wr_en,
   input  logic [INTERVAL_BITS-1:0]                  wr_data,
   output logic [INTERVAL_BITS+$clog2(RING_DEPTH)-1:0] sum,
   output logic [$clog2(RING_DEPTH+1)-1:0]           count
);

   localparam int SUM_W = INTERVAL_BITS + $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int POS_W = $clog2(RING_DEPTH);

   logic [INTERVAL_BITS-1:0] ring_ff [RING_DEPTH];
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic                     full;
   logic [INTERVAL_BITS-1:0] evicted;

   // evicted entries count as zero until the ring is full, so the entries need no reset
   assign full    = fill_ff == CNT_W'(RING_DEPTH);
   assign evicted = full ? ring_ff[pos_ff] : '0;

   always_comb begin
      pos_in  = pos_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (wr_en) begin
         pos_in  = (pos_ff == POS_W'(RING_DEPTH - 1)) ? '0 : pos_ff + POS_W'(1);
         fill_in = full ? fill_ff : fill_ff + CNT_W'(1);
         sum_in  = sum_ff + SUM_W'(wr_data) - SUM_W'(evicted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[pos_ff] <= wr_data;
      end
   end

   assign sum   = sum_ff;
   assign count = fill_ff;

endmodule

>>> hdl/pulse_rate_from_threshold_crossings_top.sv
// Pulse rate from threshold crossings: top level with control sequencer and datapath.
//
// Takes one infrared sample with its millisecond timestamp per transaction and returns one
// result: the held heart rate and a flag for a completed falling crossing. The block works on
// one sample at a time, and all divisions go through one shared divider that retires one
// quotient bit per cycle for a quotient of N = max(19, 16 + log2(RING_DEPTH)) bits. The
// fallback threshold needs no division, an adaptive one needs one, and a beat that refreshes
// the rate divides for the average interval and, if in range, for the rate. A finished result
// waits in an output register, so the next sample is taken while it sits there. No clearing
// pass is needed after reset; configuration writes are always ready.
module pulse_rate_from_threshold_crossings_top
   import prtc_pkg::*;
#(
   parameter int RING_DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_payload_type          rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int SUM_W = INTERVAL_BITS + $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int NUM_A = (SUM_W > SAMPLE_BITS + 1) ? SUM_W : SAMPLE_BITS + 1;
   localparam int NUM_W = (NUM_A > INTERVAL_BITS) ? NUM_A : INTERVAL_BITS;
   localparam int DEN_W = INTERVAL_BITS;
   localparam int PROD_W = BPM_BITS + INTERVAL_BITS;

   state_type state_ff, state_in;

   // configuration
   logic [SWING_BITS-1:0]    min_swing_ff, min_swing_in;
   logic [SWING_BITS-1:0]    fallback_ff, fallback_in;
   logic [INTERVAL_BITS-1:0] min_iv_ff, min_iv_in;
   logic [INTERVAL_BITS-1:0] max_iv_ff, max_iv_in;
   logic [BPM_BITS-1:0]      bpm_low_ff, bpm_low_in;
   logic [BPM_BITS-1:0]      bpm_high_ff, bpm_high_in;

   // detector state
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic                   armed_ff, armed_in;
   logic [TIME_BITS-1:0]   last_ff, last_in;
   logic                   btv_ff, btv_in;
   logic [MOD_BITS-1:0]    mod10_ff, mod10_in;
   logic                   two_ff, two_in;
   logic [BPM_BITS-1:0]    held_ff, held_in;
   logic                   beat_ff, beat_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // per-sample working registers
   logic [SAMPLE_BITS-1:0]   s_ff, s_in;
   logic [TIME_BITS-1:0]     now_ff, now_in;
   logic [SAMPLE_BITS-1:0]   thr_ff, thr_in;
   logic [INTERVAL_BITS-1:0] avg_ff, avg_in;
   rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   logic                     div_start;
   logic [NUM_W-1:0]         div_numer;
   logic [DEN_W-1:0]         div_denom;
   logic                     div_done;
   logic [NUM_W-1:0]         div_quot;

   logic                     ring_wr;
   logic [SUM_W-1:0]         ring_sum;
   logic [CNT_W-1:0]         ring_count;

   logic                     adaptive;
   logic [SAMPLE_BITS-1:0]   swing;
   logic                     rise;
   logic                     fall;
   logic [TIME_BITS-1:0]     interval;
   logic                     in_window;
   logic [MOD_BITS-1:0]      mod10_next;
   logic [PROD_W-1:0]        prod_low;
   logic [PROD_W-1:0]        prod_high;
   logic                     rate_ok;
   logic                     rsp_load;

   prtc_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   prtc_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_wr),
      .wr_data (interval[INTERVAL_BITS-1:0]),
      .sum     (ring_sum),
      .count   (ring_count)
   );

   assign adaptive   = {1'b0, max_ff} > ({1'b0, min_ff} + {1'b0, min_swing_ff});
   assign swing      = max_ff - min_ff;
   assign rise       = (s_ff > thr_ff) && (prev_ff <= thr_ff) && !armed_ff;
   assign fall       = (s_ff < thr_ff) && (prev_ff >= thr_ff) && armed_ff;
   assign interval   = now_ff - last_ff;
   assign in_window  = (interval > TIME_BITS'(min_iv_ff)) && (interval < TIME_BITS'(max_iv_ff));
   assign mod10_next = (mod10_ff == MOD_TEN_LAST) ? '0 : mod10_ff + MOD_BITS'(1);
   assign prod_low   = PROD_W'(bpm_low_ff) * PROD_W'(avg_ff);
   assign prod_high  = PROD_W'(bpm_high_ff) * PROD_W'(avg_ff);
   assign rate_ok    = (PROD_W'(RATE_NUMERATOR) >= prod_low)
                    && (PROD_W'(RATE_NUMERATOR) <= prod_high);

   always_comb begin
      state_in       = state_ff;
      min_swing_in   = min_swing_ff;
      fallback_in    = fallback_ff;
      min_iv_in      = min_iv_ff;
      max_iv_in      = max_iv_ff;
      bpm_low_in     = bpm_low_ff;
      bpm_high_in    = bpm_high_ff;
      max_in         = max_ff;
      min_in         = min_ff;
      prev_in        = prev_ff;
      armed_in       = armed_ff;
      last_in        = last_ff;
      btv_in         = btv_ff;
      mod10_in       = mod10_ff;
      two_in         = two_ff;
      held_in        = held_ff;
      beat_in        = beat_ff;
      s_in           = s_ff;
      now_in         = now_ff;
      thr_in         = thr_ff;
      avg_in         = avg_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_load       = 1'b0;
      div_start      = 1'b0;
      div_numer      = '0;
      div_denom      = '0;
      ring_wr        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               s_in     = req_payload.ir_sample;
               now_in   = req_payload.time_ms;
               max_in   = (req_payload.ir_sample > max_ff) ? req_payload.ir_sample : max_ff;
               min_in   = (req_payload.ir_sample < min_ff) ? req_payload.ir_sample : min_ff;
               beat_in  = 1'b0;
               state_in = ST_THRESH;
            end
         end
         ST_THRESH: begin
            if (adaptive) begin
               div_start = 1'b1;
               div_numer = NUM_W'({swing, 1'b0});
               div_denom = DEN_W'(THIRD_DIVISOR);
               state_in  = ST_THRESH_WAIT;
            end else begin
               thr_in   = fallback_ff[SAMPLE_BITS-1:0];
               state_in = ST_CROSS;
            end
         end
         ST_THRESH_WAIT: begin
            if (div_done) begin
               thr_in   = min_ff + div_quot[SAMPLE_BITS-1:0];
               state_in = ST_CROSS;
            end
         end
         ST_CROSS: begin
            prev_in  = s_ff;
            state_in = ST_FINISH;
            if (rise) begin
               armed_in = 1'b1;
            end else if (fall) begin
               armed_in = 1'b0;
               beat_in  = 1'b1;
               last_in  = now_ff;
               btv_in   = 1'b1;
               if (btv_ff && in_window) begin
                  ring_wr  = 1'b1;
                  mod10_in = mod10_next;
                  if (mod10_next >= MOD_TWO) begin
                     two_in = 1'b1;
                  end
                  if (mod10_next >= MOD_TWO || two_ff) begin
                     state_in = ST_AVG;
                  end
                  if (mod10_next == '0) begin
                     max_in = '0;
                     min_in = '1;
                  end
               end else if (mod10_ff == '0) begin
                  max_in = '0;
                  min_in = '1;
               end
            end
         end
         ST_AVG: begin
            div_start = 1'b1;
            div_numer = NUM_W'(ring_sum);
            div_denom = DEN_W'(ring_count);
            state_in  = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               avg_in   = div_quot[INTERVAL_BITS-1:0];
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (rate_ok) begin
               div_start = 1'b1;
               div_numer = NUM_W'(RATE_NUMERATOR);
               div_denom = avg_ff;
               state_in  = ST_RATE_WAIT;
            end else begin
               held_in  = '0;
               state_in = ST_FINISH;
            end
         end
         ST_RATE_WAIT: begin
            if (div_done) begin
               held_in  = div_quot[BPM_BITS-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load                 = 1'b1;
               rsp_payload_in.heart_bpm = held_ff;
               rsp_payload_in.beat_seen = beat_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_SWING:    min_swing_in = csr_wdata[SWING_BITS-1:0];
            CSR_FALLBACK_THR: fallback_in  = csr_wdata[SWING_BITS-1:0];
            CSR_MIN_INTERVAL: min_iv_in    = csr_wdata[INTERVAL_BITS-1:0];
            CSR_MAX_INTERVAL: max_iv_in    = csr_wdata[INTERVAL_BITS-1:0];
            CSR_BPM_LOW:      bpm_low_in   = csr_wdata[BPM_BITS-1:0];
            CSR_BPM_HIGH:     bpm_high_in  = csr_wdata[BPM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_swing_ff <= MIN_SWING_RESET;
         fallback_ff  <= FALLBACK_THR_RESET;
         min_iv_ff    <= MIN_INTERVAL_RESET;
         max_iv_ff    <= MAX_INTERVAL_RESET;
         bpm_low_ff   <= BPM_LOW_RESET;
         bpm_high_ff  <= BPM_HIGH_RESET;
         max_ff       <= '0;
         min_ff       <= '1;
         prev_ff      <= '0;
         armed_ff     <= 1'b0;
         last_ff      <= '0;
         btv_ff       <= 1'b0;
         mod10_ff     <= '0;
         two_ff       <= 1'b0;
         held_ff      <= '0;
         beat_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_swing_ff <= min_swing_in;
         fallback_ff  <= fallback_in;
         min_iv_ff    <= min_iv_in;
         max_iv_ff    <= max_iv_in;
         bpm_low_ff   <= bpm_low_in;
         bpm_high_ff  <= bpm_high_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         prev_ff      <= prev_in;
         armed_ff     <= armed_in;
         last_ff      <= last_in;
         btv_ff       <= btv_in;
         mod10_ff     <= mod10_in;
         two_ff       <= two_in;
         held_ff      <= held_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff           <= s_in;
      now_ff         <= now_in;
      thr_ff         <= thr_in;
      avg_ff         <= avg_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;

endmodule

>>> hdl/prtc_checker.sv
// Port-level checker for the pulse rate block and its bind to the top level.
module prtc_checker
   import prtc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   logic [BPM_BITS-1:0] last_bpm_ff, last_bpm_in;

   // track the rate of the last delivered transaction
   assign last_bpm_in = (rsp_valid && !rsp_stall) ? rsp_payload.heart_bpm : last_bpm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_bpm_ff <= '0;
      end else begin
         last_bpm_ff <= last_bpm_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second sample taken while one is in work");

   a_rate_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.beat_seen |-> rsp_payload.heart_bpm == last_bpm_ff)
      else $error("rate changed without a beat");

endmodule

bind pulse_rate_from_threshold_crossings_top prtc_checker u_prtc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

>>> bench/tb_pulse_rate_from_threshold_crossings_top.sv
// Testbench for the pulse rate block: optical pulse trains in, held rate and beat flags checked.
module tb_pulse_rate_from_threshold_crossings_top;
   import prtc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SLOTS     = 8;
   localparam int SAMPLE_TOP     = (1 << SAMPLE_BITS) - 1;
   localparam int DRAIN_CYCLES   = 80;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_payload_type          req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_payload_type          rsp_payload;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   pulse_rate_from_threshold_crossings_top #(
      .RING_DEPTH(RING_SLOTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // register copies
   logic [SWING_BITS-1:0]    cfg_min_swing;
   logic [SWING_BITS-1:0]    cfg_fallback;
   logic [INTERVAL_BITS-1:0] cfg_min_ivl;
   logic [INTERVAL_BITS-1:0] cfg_max_ivl;
   logic [BPM_BITS-1:0]      cfg_bpm_low;
   logic [BPM_BITS-1:0]      cfg_bpm_high;

   // beat tracker state
   logic [SAMPLE_BITS-1:0]   peak_hi;
   logic [SAMPLE_BITS-1:0]   peak_lo;
   logic [SAMPLE_BITS-1:0]   prev_level;
   logic                     armed_q;
   logic [TIME_BITS-1:0]     last_beat_ms;
   logic                     beat_known;
   logic [INTERVAL_BITS-1:0] ivl_ring [RING_SLOTS];
   logic [2:0]               ring_pos;
   logic [MOD_BITS-1:0]      valid_mod10;
   logic                     two_seen;
   logic [BPM_BITS-1:0]      rate_q;

   rsp_payload_type          readings_due[$];
   int                       fail_count = 0;
   int                       quiet_cycles = 0;
   int                       stall_left = 0;
   bit                       traffic_gaps = 1'b1;
   logic [TIME_BITS-1:0]     stamp_ms = '0;

   // Advance the tracker by one sample and return the reading it produces.
   function automatic rsp_payload_type rate_after_sample(input logic [SAMPLE_BITS-1:0] level,
                                                         input logic [TIME_BITS-1:0] at_ms);
      longint unsigned hi, lo, thr, sum, cnt, avg;
      logic [TIME_BITS-1:0] gap_ms;
      rsp_payload_type r;
      r.beat_seen = 1'b0;
      if (level > peak_hi) peak_hi = level;
      if (level < peak_lo) peak_lo = level;
      hi = peak_hi;
      lo = peak_lo;
      if (hi > lo + cfg_min_swing)
         thr = lo + (hi - lo) * 2 / 3;
      else
         thr = cfg_fallback;

      if (level > thr && prev_level <= thr && !armed_q) begin
         armed_q = 1'b1;
      end else if (level < thr && prev_level >= thr && armed_q) begin
         armed_q = 1'b0;
         r.beat_seen = 1'b1;
         if (beat_known) begin
            gap_ms = at_ms - last_beat_ms;
            if (gap_ms > cfg_min_ivl && gap_ms < cfg_max_ivl) begin
               ivl_ring[ring_pos] = gap_ms[INTERVAL_BITS-1:0];
               ring_pos = ring_pos + 1'b1;
               valid_mod10 = (valid_mod10 == MOD_TEN_LAST) ? '0 : valid_mod10 + 1'b1;
               if (valid_mod10 >= MOD_TWO) two_seen = 1'b1;
               if (two_seen) begin
                  sum = 0;
                  cnt = 0;
                  for (int i = 0; i < RING_SLOTS; i++) begin
                     if (ivl_ring[i] != 0) begin
                        sum += ivl_ring[i];
                        cnt++;
                     end
                  end
                  if (cnt != 0) begin
                     avg = sum / cnt;
                     if (avg != 0) begin
                        if (60000 >= cfg_bpm_low * avg && 60000 <= cfg_bpm_high * avg)
                           rate_q = BPM_BITS'(60000 / avg);
                        else
                           rate_q = '0;
                     end
                  end
               end
            end
         end
         last_beat_ms = at_ms;
         beat_known = 1'b1;
         // restart extreme tracking on a beat while the valid beat count is a multiple of ten
         if (valid_mod10 == 0) begin
            peak_hi = '0;
            peak_lo = '1;
         end
      end
      prev_level = level;
      r.heart_bpm = rate_q;
      return r;
   endfunction

   // Send one sample, with an optional random hold-off before it.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] level,
                              input logic [TIME_BITS-1:0] at_ms);
      req_payload_type p;
      if (traffic_gaps && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      p.time_ms = at_ms;
      p.ir_sample = level;
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      readings_due.push_back(rate_after_sample(level, at_ms));
   endtask

   task automatic settle_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_due.size() != 0) @(posedge clock);
   endtask

   task automatic program_csrs(input logic [SWING_BITS-1:0] swing, fallback,
                               input logic [INTERVAL_BITS-1:0] ivl_lo, ivl_hi,
                               input logic [BPM_BITS-1:0] rate_lo, rate_hi);
      logic [CSR_IDX_BITS-1:0]  regs [6];
      logic [CSR_DATA_BITS-1:0] vals [6];
      settle_drained();
      regs = '{CSR_MIN_SWING, CSR_FALLBACK_THR, CSR_MIN_INTERVAL,
               CSR_MAX_INTERVAL, CSR_BPM_LOW, CSR_BPM_HIGH};
      vals = '{swing, fallback, CSR_DATA_BITS'(ivl_lo), CSR_DATA_BITS'(ivl_hi),
               CSR_DATA_BITS'(rate_lo), CSR_DATA_BITS'(rate_hi)};
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (regs[i])
            CSR_MIN_SWING:    cfg_min_swing = vals[i];
            CSR_FALLBACK_THR: cfg_fallback  = vals[i];
            CSR_MIN_INTERVAL: cfg_min_ivl   = vals[i][INTERVAL_BITS-1:0];
            CSR_MAX_INTERVAL: cfg_max_ivl   = vals[i][INTERVAL_BITS-1:0];
            CSR_BPM_LOW:      cfg_bpm_low   = vals[i][BPM_BITS-1:0];
            CSR_BPM_HIGH:     cfg_bpm_high  = vals[i][BPM_BITS-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Pulse trains: a high plateau then a low stretch per beat, with noise, odd periods,
   // stray samples and timestamp jumps mixed in.
   task automatic drive_pulse_items(input int n_items);
      int sent, period, step, slots, hi, lo, v;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0)
            period = $urandom_range(50, 3000);
         else
            period = $urandom_range(280, 1600);
         step = $urandom_range(20, 90);
         slots = period / step;
         if (slots < 2) slots = 2;
         hi = $urandom_range(90000, SAMPLE_TOP);
         lo = $urandom_range(0, 60000);
         if ($urandom_range(0, 15) == 0) stamp_ms = $urandom();
         for (int k = 0; k < slots && sent < n_items; k++) begin
            if ($urandom_range(0, 24) == 0)
               v = $urandom_range(0, SAMPLE_TOP);
            else
               v = ((k < (slots + 2) / 3) ? hi : lo) + $urandom_range(0, 1500);
            if (v > SAMPLE_TOP) v = SAMPLE_TOP;
            stamp_ms = stamp_ms + step;
            send_sample(SAMPLE_BITS'(v), stamp_ms);
            sent++;
         end
      end
   endtask

   // First beat at time zero, short interval, timestamp wrap, samples right on the threshold.
   task automatic test_directed();
      send_sample('0, 32'd0);
      send_sample(SAMPLE_BITS'(SAMPLE_TOP), 32'd10);
      send_sample('0, 32'd0);
      send_sample(SAMPLE_BITS'(SAMPLE_TOP), 32'd500);
      send_sample('0, 32'd900);
      send_sample(SAMPLE_BITS'(SAMPLE_TOP), 32'd1000);
      send_sample('0, 32'd1100);
      send_sample(SAMPLE_BITS'(SAMPLE_TOP), 32'd1200);
      send_sample('0, 32'd1900);
      send_sample(SAMPLE_BITS'(SAMPLE_TOP), 32'hFFFF_FE00);
      send_sample('0, 32'hFFFF_FFFF);
      send_sample(SAMPLE_BITS'(SAMPLE_TOP), 32'd100);
      send_sample('0, 32'd500);
      send_sample(18'd174762, 32'd600);
      send_sample(18'd174763, 32'd650);
      send_sample(18'd174762, 32'd1000);
      send_sample(18'd174761, 32'd1200);
      stamp_ms = 32'd2000;
   endtask

   task automatic test_config_extremes();
      // swing can never pass the limit and nothing exceeds the fallback
      program_csrs('1, '1, '0, '1, '0, '1);
      drive_pulse_items(25);
      // zero fallback: arm on a rise from zero, never fall below
      program_csrs('1, '0, '0, '1, '0, '1);
      drive_pulse_items(25);
      // inverted rate bounds force a zero rate on every recompute
      program_csrs('0, 18'd100000, 16'd200, 16'd2000, 8'd200, 8'd30);
      drive_pulse_items(60);
   endtask

   task automatic test_random_pulses();
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 1)
            program_csrs(SWING_BITS'($urandom_range(0, 4000)),
                         SWING_BITS'($urandom_range(30000, 150000)),
                         '0, '1, '0, '1);
         else
            program_csrs(SWING_BITS'($urandom_range(0, 4000)),
                         SWING_BITS'($urandom_range(30000, 150000)),
                         INTERVAL_BITS'($urandom_range(200, 400)),
                         INTERVAL_BITS'($urandom_range(1100, 2200)),
                         BPM_BITS'($urandom_range(20, 70)),
                         BPM_BITS'($urandom_range(140, 255)));
         if (phase == 2) stamp_ms = 32'hFFFF_F000;
         drive_pulse_items(200);
      end
   endtask

   task automatic test_pressure_pause();
      program_csrs(MIN_SWING_RESET, FALLBACK_THR_RESET, MIN_INTERVAL_RESET,
                   MAX_INTERVAL_RESET, BPM_LOW_RESET, BPM_HIGH_RESET);
      drive_pulse_items(40);
      // hold the sender until every reading is back
      settle_drained();
      drive_pulse_items(40);
   endtask

   task automatic test_no_gaps();
      traffic_gaps = 1'b0;
      program_csrs(SWING_BITS'($urandom_range(0, 2000)),
                   SWING_BITS'($urandom_range(40000, 120000)),
                   MIN_INTERVAL_RESET, MAX_INTERVAL_RESET, BPM_LOW_RESET, BPM_HIGH_RESET);
      drive_pulse_items(150);
   endtask

   always @(posedge clock) begin
      if (reset || !traffic_gaps) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(1, 18);
      end
   end

   always @(posedge clock) begin : reading_check
      rsp_payload_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (readings_due.size() == 0) begin
            $error("unexpected transaction: heart_bpm %0d beat_seen %0d",
                   rsp_payload.heart_bpm, rsp_payload.beat_seen);
            fail_count++;
         end else begin
            due = readings_due.pop_front();
            if (rsp_payload.heart_bpm !== due.heart_bpm) begin
               $error("heart_bpm: expected %0d, got %0d", due.heart_bpm, rsp_payload.heart_bpm);
               fail_count++;
            end
            if (rsp_payload.beat_seen !== due.beat_seen) begin
               $error("beat_seen: expected %0d, got %0d", due.beat_seen, rsp_payload.beat_seen);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      cfg_min_swing = MIN_SWING_RESET;
      cfg_fallback  = FALLBACK_THR_RESET;
      cfg_min_ivl   = MIN_INTERVAL_RESET;
      cfg_max_ivl   = MAX_INTERVAL_RESET;
      cfg_bpm_low   = BPM_LOW_RESET;
      cfg_bpm_high  = BPM_HIGH_RESET;
      peak_hi       = '0;
      peak_lo       = '1;
      prev_level    = '0;
      armed_q       = 1'b0;
      last_beat_ms  = '0;
      beat_known    = 1'b0;
      for (int i = 0; i < RING_SLOTS; i++) ivl_ring[i] = '0;
      ring_pos      = '0;
      valid_mod10   = '0;
      two_seen      = 1'b0;
      rate_q        = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_config_extremes();
      test_random_pulses();
      test_pressure_pause();
      test_no_gaps();

      settle_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && readings_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (readings_due.size() != 0)
            $error("%0d expected transactions never arrived", readings_due.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/prtc_pkg.sv
hdl/prtc_div.sv
hdl/prtc_ring.sv
hdl/pulse_rate_from_threshold_crossings_top.sv
hdl/prtc_checker.sv
bench/tb_pulse_rate_from_threshold_crossings_top.sv
